// ----- hdl/bsa_pkg.sv -----
// bsa_pkg: widths, codes and constants shared by the slot allocator files
// no dependencies
`default_nettype none

package bsa_pkg;

  localparam int ADDR_W = 32;
  localparam int UNIT_W = 13;
  localparam int CFG_W  = 32;

  localparam logic [ADDR_W-1:0] SLOT_HEADER = 32'd8;
  localparam logic [UNIT_W-1:0] UNIT_RESET  = 13'd16;
  localparam logic [ADDR_W-1:0] BASE_RESET  = 32'd0;

  typedef enum logic {
    CFG_UNIT_SIZE    = 1'b0,
    CFG_BASE_ADDRESS = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

endpackage

`default_nettype wire

// ----- hdl/bsa_in_if.sv -----
// bsa_in_if: request channel of the slot allocator, valid/ready with payload
// depends on bsa_pkg
`default_nettype none

interface bsa_in_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

`default_nettype wire

// ----- hdl/bsa_out_if.sv -----
// bsa_out_if: result channel of the slot allocator, valid/ready with payload
// depends on bsa_pkg
`default_nettype none

interface bsa_out_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] slot_address;
  logic              page_full;
  logic              page_empty;

  modport source (output valid, output ok, output slot_address, output page_full,
                  output page_empty, input ready);
  modport sink   (input valid, input ok, input slot_address, input page_full,
                  input page_empty, output ready);
endinterface

`default_nettype wire

// ----- hdl/bitmap_slot_allocator.sv -----
// bitmap_slot_allocator: first fit slot allocator over an occupancy bitmap in ram
// depends on bsa_pkg, bsa_in_if, bsa_out_if, bsa_ram
// Each request returns one result. An allocate reads the first word that is not
// full, writes it back with the lowest clear bit set, then does a multiply and an
// add for the address. A free runs the restoring divider that resolves first the
// word and then the bit, one quotient bit per cycle, then the read-modify-write of
// that word. Requests are handled one at a time; a new request is taken while the
// previous result waits in the output register. The bitmap needs no clearing pass
// after reset: a valid bit per word makes an unwritten word read as all free, and
// per-word full and nonzero flags give the page status.
`default_nettype none

module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int MAP_WORDS = 4,
  parameter int WORD_BITS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bsa_in_if.sink                in_ch,
  bsa_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int WA_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int TOTAL  = MAP_WORDS * WORD_BITS;
  localparam int IDX_W  = $clog2(TOTAL + 1);
  localparam int PROD_W = IDX_W + UNIT_W;
  localparam int REG_W  = UNIT_W + IDX_W;
  localparam int CMP_W  = ADDR_W + 1;
  localparam int QW     = WA_W + BIT_W;
  localparam int CNT_W  = $clog2(QW + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_FRD  = 9'b000001000,
    S_FWR  = 9'b000010000,
    S_AWR  = 9'b000100000,
    S_AMUL = 9'b001000000,
    S_AADD = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [UNIT_W-1:0]     unit_size_r, unit_size_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [MAP_WORDS-1:0]  vld_r, vld_nxt;
  logic [MAP_WORDS-1:0]  full_r, full_nxt;
  logic [MAP_WORDS-1:0]  nz_r, nz_nxt;
  logic [ADDR_W-1:0]     rem_r, rem_nxt;
  logic [ADDR_W-1:0]     dsh_r, dsh_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [WA_W-1:0]       waddr_r, waddr_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  ok_r, ok_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [ADDR_W-1:0]     out_slot_r, out_slot_nxt;
  logic                  out_full_r, out_full_nxt;
  logic                  out_empty_r, out_empty_nxt;

  logic                  ram_we;
  logic [WA_W-1:0]       ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic [WORD_BITS-1:0]  rd_word;
  logic [WA_W-1:0]       fw_idx;
  logic                  fw_hit;
  logic [BIT_W-1:0]      zb;
  logic [REG_W-1:0]      region;
  logic                  out_free;
  logic                  page_full;
  logic                  page_empty;

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // unwritten words read as all free
  assign rd_word    = vld_r[waddr_r] ? ram_rdata : '0;
  assign region     = REG_W'(unit_size_r) * REG_W'(TOTAL);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign page_full  = &full_r;
  assign page_empty = ~|nz_r;

  // first word with a clear bit
  always_comb begin
    fw_idx = '0;
    fw_hit = 1'b0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        fw_idx = WA_W'(i);
        fw_hit = 1'b1;
      end
    end
  end

  // lowest clear bit of the word just read
  always_comb begin
    zb = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_word[i]) begin
        zb = BIT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    unit_size_nxt = unit_size_r;
    base_nxt      = base_r;
    vld_nxt       = vld_r;
    full_nxt      = full_r;
    nz_nxt        = nz_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    waddr_nxt     = waddr_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    out_full_nxt  = out_full_r;
    out_empty_nxt = out_empty_r;
    ram_we        = 1'b0;
    ram_raddr     = waddr_r;
    ram_wdata     = rd_word;

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_UNIT_SIZE:    unit_size_nxt = cfg_wdata[UNIT_W-1:0];
        CFG_BASE_ADDRESS: base_nxt      = cfg_wdata[ADDR_W-1:0];
        default:          unit_size_nxt = unit_size_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (mode_t'(in_ch.mode) == MODE_FREE) begin
            rem_nxt   = in_ch.address - SLOT_HEADER - base_r;
            state_nxt = S_CHK;
          end else if (fw_hit) begin
            waddr_nxt = fw_idx;
            ram_raddr = fw_idx;
            state_nxt = S_AWR;
          end else begin
            ok_nxt    = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end
      S_CHK: begin
        cnt_nxt = '0;
        q_nxt   = '0;
        dsh_nxt = (ADDR_W'(unit_size_r) * ADDR_W'(WORD_BITS)) << (WA_W - 1);
        if (unit_size_r != '0 && CMP_W'(rem_r) < CMP_W'(region)) begin
          state_nxt = S_DIV;
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          q_nxt   = {q_r[QW-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[QW-2:0], 1'b0};
        end
        if (cnt_r == CNT_W'(WA_W - 1)) begin
          dsh_nxt = ADDR_W'(unit_size_r) << (BIT_W - 1);
        end else begin
          dsh_nxt = dsh_r >> 1;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QW - 1)) begin
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        waddr_nxt = q_r[QW-1:BIT_W];
        bit_nxt   = q_r[BIT_W-1:0];
        ram_raddr = q_r[QW-1:BIT_W];
        state_nxt = S_FWR;
      end
      S_FWR: begin
        ram_wdata         = rd_word & ~(WORD_BITS'(1) << bit_r);
        ram_we            = 1'b1;
        vld_nxt[waddr_r]  = 1'b1;
        full_nxt[waddr_r] = &ram_wdata;
        nz_nxt[waddr_r]   = |ram_wdata;
        ok_nxt            = 1'b1;
        state_nxt         = S_FIN;
      end
      S_AWR: begin
        ram_wdata         = rd_word | (WORD_BITS'(1) << zb);
        ram_we            = 1'b1;
        vld_nxt[waddr_r]  = 1'b1;
        full_nxt[waddr_r] = &ram_wdata;
        nz_nxt[waddr_r]   = |ram_wdata;
        idx_nxt           = IDX_W'(waddr_r) * IDX_W'(WORD_BITS) + IDX_W'(zb);
        state_nxt         = S_AMUL;
      end
      S_AMUL: begin
        prod_nxt  = PROD_W'(idx_r) * PROD_W'(unit_size_r);
        state_nxt = S_AADD;
      end
      S_AADD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_slot_nxt  = base_r + SLOT_HEADER + ADDR_W'(prod_r);
          out_full_nxt  = page_full;
          out_empty_nxt = page_empty;
          state_nxt     = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_slot_nxt  = '0;
          out_full_nxt  = page_full;
          out_empty_nxt = page_empty;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      unit_size_r <= UNIT_RESET;
      base_r      <= BASE_RESET;
      vld_r       <= '0;
      full_r      <= '0;
      nz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      unit_size_r <= unit_size_nxt;
      base_r      <= base_nxt;
      vld_r       <= vld_nxt;
      full_r      <= full_nxt;
      nz_r        <= nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    waddr_r     <= waddr_nxt;
    bit_r       <= bit_nxt;
    idx_r       <= idx_nxt;
    prod_r      <= prod_nxt;
    ok_r        <= ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_slot_r  <= out_slot_nxt;
    out_full_r  <= out_full_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.slot_address = out_slot_r;
  assign out_ch.page_full    = out_full_r;
  assign out_ch.page_empty   = out_empty_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.page_full && out_ch.page_empty))
    else $error("page reported both full and empty");

  a_alloc_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AADD) |-> !page_empty)
    else $error("granted slot but bitmap shows empty");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(QW)))
    else $error("divider ran past its last quotient bit");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request taken while one is in progress");

endmodule

`default_nettype wire

// ----- hdl/bsa_ram.sv -----
// bsa_ram: generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
